// File: rtl/vpd_pkg.sv
// Shared constants, register codes and the divider status type for the vector point to DAC block.
`default_nettype none
package vpd_pkg;

  // Coordinate width default, dividend width, speed width and ramp width
  localparam int COORD_BITS_DEF = 10;
  localparam int NUM_W          = 16;
  localparam int SPEED_W        = 11;
  localparam int RAMP_W         = 12;

  localparam logic [NUM_W-1:0]   NUM_RESET = NUM_W'(32 * 1024);
  localparam logic [SPEED_W-1:0] SPEED_MAX = 11'h7FF;
  localparam logic [RAMP_W-1:0]  MSB_FLIP  = 12'h800;

  // DAC latch register numbers
  localparam logic [2:0] REG_X_HI_FWD = 3'd5;
  localparam logic [2:0] REG_Y_HI_FWD = 3'd2;
  localparam logic [2:0] REG_LO_FWD   = 3'd4;
  localparam logic [2:0] REG_X_HI_REV = 3'd3;
  localparam logic [2:0] REG_Y_HI_REV = 3'd0;
  localparam logic [2:0] REG_LO_REV   = 3'd1;
  localparam logic [2:0] REG_RAMP_HI  = 3'd6;
  localparam logic [2:0] REG_RAMP_LO  = 3'd7;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/vpd_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vpd_divider #(
  parameter int DIV_W = vpd_pkg::COORD_BITS_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [vpd_pkg::NUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]         divisor,
  output vpd_pkg::div_stat_t            stat,
  output logic [vpd_pkg::NUM_W-1:0]     quotient
);
  import vpd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      q_nxt   = {q_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule
`default_nettype wire

// File: rtl/vector_point_to_dac_writes.sv
// Top level: point sequencer, distance estimate, shared divider and DAC write beats.
// Each accepted point produces five write beats: x high, y high, packed low bits
// (register set chosen by the ramp direction), then ramp high and ramp low with
// out_last set. A point passes from accept to accept through these steps: the idle
// state that takes it, the delta, the alpha-max-beta-min distance, the divider launch,
// sixteen restoring divider steps and the quotient collect, then the five output beats,
// which wait while out_ready is low. A zero distance skips the divider and the speed
// saturates. in_ready is high only between points. ramp_numerator is written through
// the cfg port (always ready) and resets to 32768.
`default_nettype none
module vector_point_to_dac_writes #(
  parameter int COORD_BITS = vpd_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_target_x,
  input  wire logic signed [COORD_BITS-1:0] in_target_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        out_dac_register,
  output logic [7:0]                        out_data_byte,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [vpd_pkg::NUM_W-1:0]    cfg_data
);
  import vpd_pkg::*;

  localparam int FINE_BITS = COORD_BITS - 8;
  localparam int DIST_W    = COORD_BITS + 1;
  localparam int SUM_W     = COORD_BITS + 9;

  localparam logic [2:0] BEAT_X_HI   = 3'd0;
  localparam logic [2:0] BEAT_Y_HI   = 3'd1;
  localparam logic [2:0] BEAT_LOW    = 3'd2;
  localparam logic [2:0] BEAT_RAMP_H = 3'd3;
  localparam logic [2:0] BEAT_RAMP_L = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DIST,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_W-1:0]    numer_r, numer_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [COORD_BITS-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [RAMP_W-1:0]   ramp_r, ramp_nxt;
  logic [2:0]          beat_r, beat_nxt;
  logic                dir_r, dir_nxt;

  logic [COORD_BITS-1:0] hi, lo;
  logic [SUM_W-1:0]    sum;
  logic [SPEED_W-1:0]  speed;
  logic                speed_sel;
  logic [RAMP_W-1:0]   speed12, ramp_val;
  logic [7:0]          packed_low;
  logic                div_start;
  div_stat_t           div_stat;
  logic [NUM_W-1:0]    quotient;
  logic                out_fire;

  vpd_divider #(
    .DIV_W (DIST_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numer_r),
    .divisor  (dist_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_EMIT);
  assign out_fire  = out_valid && out_ready;
  assign div_start = (state_r == ST_DIV_GO) && (dist_r != '0);

  // Alpha-max-beta-min distance from the registered deltas
  always_comb begin
    hi  = (ax_r < ay_r) ? ay_r : ax_r;
    lo  = (ax_r < ay_r) ? ax_r : ay_r;
    sum = SUM_W'(hi) * SUM_W'(246) + SUM_W'(lo) * SUM_W'(102);
  end

  // Clamp the quotient (full speed outside the divider wait), apply direction and flip the ramp MSB
  always_comb begin
    speed_sel = (state_r == ST_DIV_WAIT);
    if (!speed_sel) begin
      speed = SPEED_MAX;
    end else if (quotient[NUM_W-1:SPEED_W] != '0) begin
      speed = SPEED_MAX;
    end else begin
      speed = quotient[SPEED_W-1:0];
    end
    speed12  = {1'b0, speed};
    ramp_val = (dir_r ? (RAMP_W'(0) - speed12) : speed12) ^ MSB_FLIP;
  end

  // Pack the low coordinate bits: x low above y low
  always_comb begin
    packed_low = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < FINE_BITS) begin
        packed_low[i] = cur_y_r[i];
      end else if (i < 2 * FINE_BITS) begin
        packed_low[i] = cur_x_r[i - FINE_BITS];
      end
    end
  end

  // Select the payload of the current beat
  always_comb begin
    out_dac_register = '0;
    out_data_byte    = '0;
    out_last         = 1'b0;
    case (beat_r)
      BEAT_X_HI: begin
        out_dac_register = dir_r ? REG_X_HI_REV : REG_X_HI_FWD;
        out_data_byte    = cur_x_r[COORD_BITS-1:FINE_BITS];
      end
      BEAT_Y_HI: begin
        out_dac_register = dir_r ? REG_Y_HI_REV : REG_Y_HI_FWD;
        out_data_byte    = cur_y_r[COORD_BITS-1:FINE_BITS];
      end
      BEAT_LOW: begin
        out_dac_register = dir_r ? REG_LO_REV : REG_LO_FWD;
        out_data_byte    = packed_low;
      end
      BEAT_RAMP_H: begin
        out_dac_register = REG_RAMP_HI;
        out_data_byte    = ramp_r[RAMP_W-1:4];
      end
      BEAT_RAMP_L: begin
        out_dac_register = REG_RAMP_LO;
        out_data_byte    = {4'b0, ramp_r[3:0]};
        out_last         = 1'b1;
      end
      default: begin
        out_dac_register = '0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt  = state_r;
    numer_nxt  = numer_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    dist_nxt   = dist_r;
    ramp_nxt   = ramp_r;
    beat_nxt   = beat_r;
    dir_nxt    = dir_r;
    if (cfg_valid && cfg_ready) begin
      numer_nxt = cfg_data;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_x_nxt = {~in_target_x[COORD_BITS-1], in_target_x[COORD_BITS-2:0]};
          cur_y_nxt = {~in_target_y[COORD_BITS-1], in_target_y[COORD_BITS-2:0]};
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        ax_nxt     = (cur_x_r >= prev_x_r) ? cur_x_r - prev_x_r : prev_x_r - cur_x_r;
        ay_nxt     = (cur_y_r >= prev_y_r) ? cur_y_r - prev_y_r : prev_y_r - cur_y_r;
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        state_nxt  = ST_DIST;
      end
      ST_DIST: begin
        dist_nxt  = sum[SUM_W-1:8];
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        // Zero distance saturates without dividing
        if (dist_r == '0) begin
          ramp_nxt  = ramp_val;
          beat_nxt  = BEAT_X_HI;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          ramp_nxt  = ramp_val;
          beat_nxt  = BEAT_X_HI;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (beat_r == BEAT_RAMP_L) begin
            dir_nxt   = ~dir_r;
            state_nxt = ST_IDLE;
          end else begin
            beat_nxt = beat_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      numer_r  <= NUM_RESET;
      prev_x_r <= '0;
      prev_y_r <= '0;
      dir_r    <= 1'b1;
      beat_r   <= BEAT_X_HI;
    end else begin
      state_r  <= state_nxt;
      numer_r  <= numer_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      dir_r    <= dir_nxt;
      beat_r   <= beat_nxt;
    end
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    dist_r  <= dist_nxt;
    ramp_r  <= ramp_nxt;
  end

  // Never take a point while beats are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output beats pending");

  // Return to idle right after the ramp low beat
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after last beat");

  // The divider is never busy once beats are being sent
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !div_stat.busy)
    else $error("divider busy during output beats");

  // An accepted point blocks the input on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for vector_point_to_dac_writes: directed points, random walks and numerator sweeps.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vpd_pkg::*;

  localparam int CB           = COORD_BITS_DEF;
  localparam int LB           = CB - 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_POINTS = 40;
  localparam int TABLE_ROWS   = 21;

  // One DAC register write beat
  typedef struct packed {
    logic [2:0] reg_no;
    logic [7:0] data;
    logic       strobe;
  } dac_write_t;

  // Directed row: either a numerator write or a point, with an optional typed ramp word
  typedef struct packed {
    logic                   is_cfg;
    logic [NUM_W-1:0]       num;
    logic signed [CB-1:0]   x;
    logic signed [CB-1:0]   y;
    logic                   known;
    logic [RAMP_W-1:0]      ramp;
  } plot_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CB-1:0] in_target_x = '0;
  logic signed [CB-1:0] in_target_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_dac_register;
  logic [7:0]           out_data_byte;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [NUM_W-1:0]     cfg_data = '0;

  // Predictor state
  logic [CB-1:0]    beam_x = '0;
  logic [CB-1:0]    beam_y = '0;
  logic             ramp_rev = 1'b1;
  logic [NUM_W-1:0] ramp_num = NUM_RESET;

  dac_write_t dac_writes_due[$];
  dac_write_t want;
  int         mismatches = 0;
  int         points_sent = 0;
  int         idle_cycles = 0;
  bit         idle_en = 1'b1;
  bit         hold_done = 1'b0;
  int         stall_left = 0;

  plot_row_t plot_table [TABLE_ROWS] = '{
    '{1'b0, 16'd0,     -10'sd512, -10'sd512, 1'b1, 12'h001},
    '{1'b0, 16'd0,      10'sd511,  10'sd511, 1'b0, 12'h000},
    '{1'b0, 16'd0,      10'sd511,  10'sd511, 1'b1, 12'h001},
    '{1'b0, 16'd0,      10'sd511,  10'sd511, 1'b1, 12'hFFF},
    '{1'b0, 16'd0,      10'sd510,  10'sd510, 1'b0, 12'h000},
    '{1'b0, 16'd0,      10'sd0,    -10'sd1,  1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd1,     10'sd0,  1'b0, 12'h000},
    '{1'b0, 16'd0,      10'sd341, -10'sd342, 1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd342,  10'sd341, 1'b0, 12'h000},
    '{1'b1, 16'hFFFF,   10'sd0,    10'sd0,   1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd512,  10'sd511, 1'b0, 12'h000},
    '{1'b0, 16'd0,      10'sd511, -10'sd512, 1'b0, 12'h000},
    '{1'b0, 16'd0,      10'sd510, -10'sd511, 1'b0, 12'h000},
    '{1'b1, 16'd1,      10'sd0,    10'sd0,   1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd512, -10'sd512, 1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd511, -10'sd511, 1'b0, 12'h000},
    '{1'b1, 16'd0,      10'sd0,    10'sd0,   1'b0, 12'h000},
    // zero numerator with a nonzero distance always lands on the MSB flip alone
    '{1'b0, 16'd0,      10'sd200, -10'sd100, 1'b1, MSB_FLIP},
    '{1'b0, 16'd0,      10'sd200, -10'sd100, 1'b0, 12'h000},
    '{1'b0, 16'd0,     -10'sd3,    10'sd7,   1'b1, MSB_FLIP},
    '{1'b1, NUM_RESET,  10'sd0,    10'sd0,   1'b0, 12'h000}
  };

  vector_point_to_dac_writes uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dac_register (out_dac_register),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Work out the five write beats for one point and advance the beam state
  task automatic plot_point(input logic signed [CB-1:0] tx, input logic signed [CB-1:0] ty,
                            input logic known, input logic [RAMP_W-1:0] typed);
    logic [CB-1:0]     nx;
    logic [CB-1:0]     ny;
    logic [CB-1:0]     dx;
    logic [CB-1:0]     dy;
    logic [CB-1:0]     hi;
    logic [CB-1:0]     lo;
    int                seg_len;
    int                speed;
    logic [RAMP_W-1:0] word;
    nx = {~tx[CB-1], tx[CB-2:0]};
    ny = {~ty[CB-1], ty[CB-2:0]};
    dx = (nx >= beam_x) ? nx - beam_x : beam_x - nx;
    dy = (ny >= beam_y) ? ny - beam_y : beam_y - ny;
    hi = (dx < dy) ? dy : dx;
    lo = (dx < dy) ? dx : dy;
    seg_len = (246 * int'(hi) + 102 * int'(lo)) >> 8;
    speed = (seg_len == 0) ? int'(SPEED_MAX) : int'(ramp_num) / seg_len;
    if (speed > int'(SPEED_MAX)) speed = int'(SPEED_MAX);
    word = RAMP_W'(speed);
    if (ramp_rev) word = RAMP_W'(0) - word;
    word = word ^ MSB_FLIP;
    if (known) word = typed;
    dac_writes_due.push_back('{ramp_rev ? REG_X_HI_REV : REG_X_HI_FWD, nx[CB-1:LB], 1'b0});
    dac_writes_due.push_back('{ramp_rev ? REG_Y_HI_REV : REG_Y_HI_FWD, ny[CB-1:LB], 1'b0});
    dac_writes_due.push_back('{ramp_rev ? REG_LO_REV : REG_LO_FWD,
                               8'({nx[LB-1:0], ny[LB-1:0]}), 1'b0});
    dac_writes_due.push_back('{REG_RAMP_HI, word[RAMP_W-1:4], 1'b0});
    dac_writes_due.push_back('{REG_RAMP_LO, 8'(word[3:0]), 1'b1});
    beam_x = nx;
    beam_y = ny;
    ramp_rev = ~ramp_rev;
  endtask

  // Offer one point, with an optional gap first; leave valid high after the beat
  task automatic send_point(input logic signed [CB-1:0] tx, input logic signed [CB-1:0] ty,
                            input logic known, input logic [RAMP_W-1:0] typed);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_target_x = tx;
    in_target_y = ty;
    do @(posedge clk); while (!in_ready);
    plot_point(tx, ty, known, typed);
    points_sent++;
  endtask

  // Write the numerator once every pending beat has drained
  task automatic write_ramp_num(input logic [NUM_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (dac_writes_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    ramp_num = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int wander(input int c);
    int v;
    v = c + int'($urandom_range(0, 16)) - 8;
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return v;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 3))
      0: return -512;
      1: return 511;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold-off to back up the input
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && points_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (idle_en && stall_left == 0 && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
          out_ready = 1'b0;
          stall_left--;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  // Compare each write beat with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dac_writes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat reg %0d data %02h last %0b",
                                out_dac_register, out_data_byte, out_last));
      end else begin
        want = dac_writes_due.pop_front();
        if (out_dac_register !== want.reg_no)
          note_mismatch($sformatf("dac_register %0d, expected %0d",
                                  out_dac_register, want.reg_no));
        if (out_data_byte !== want.data)
          note_mismatch($sformatf("data_byte %02h, expected %02h (reg %0d)",
                                  out_data_byte, want.data, want.reg_no));
        if (out_last !== want.strobe)
          note_mismatch($sformatf("last %0b, expected %0b (reg %0d)",
                                  out_last, want.strobe, want.reg_no));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int               cx;
    int               cy;
    logic [NUM_W-1:0] phase_num;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows
    foreach (plot_table[i]) begin
      if (plot_table[i].is_cfg)
        write_ramp_num(plot_table[i].num);
      else
        send_point(plot_table[i].x, plot_table[i].y, plot_table[i].known, plot_table[i].ramp);
    end
    cx = 0;
    cy = 0;

    // Random phases, each under its own numerator; the third and the last run without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: phase_num = 16'hFFFF;
        1: phase_num = 16'($urandom_range(1, 65535));
        2: phase_num = 16'($urandom_range(1, 255));
        3: phase_num = 16'($urandom_range(1, 65535));
        default: phase_num = NUM_RESET;
      endcase
      write_ramp_num(phase_num);
      idle_en = (p != 2) && (p != RAND_PHASES - 1);
      for (int k = 0; k < PHASE_POINTS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            cx = int'($urandom_range(0, 1023)) - 512;
            cy = int'($urandom_range(0, 1023)) - 512;
          end
          4, 5, 6, 7: begin
            cx = wander(cx);
            cy = wander(cy);
          end
          8: ;
          default: begin
            cx = pick_edge();
            cy = pick_edge();
          end
        endcase
        send_point(CB'(cx), CB'(cy), 1'b0, '0);
      end
    end

    // Drain and report
    @(negedge clk);
    in_valid = 1'b0;
    while (dac_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
